// ===== hdl/pwmdw_pkg.sv =====
// Shared types and constants of the PWM divider and wrap solver.
package pwmdw_pkg;

   localparam int unsigned CLK_W   = 28;
   localparam int unsigned FREQ_W  = 16;
   localparam int unsigned DUTY_W  = 16;
   localparam int unsigned DIV_W   = 12;
   localparam int unsigned WRAP_W  = 16;
   localparam int unsigned LEVEL_W = 16;
   localparam int unsigned QUO_W   = 32;
   localparam int unsigned ADDR_W  = 3;

   localparam logic [CLK_W-1:0] CLK_RESET = 28'd125000000;

   localparam logic [QUO_W-1:0] DIV_MIN  = 32'd16;
   localparam logic [QUO_W-1:0] DIV_MAX  = 32'd4096;
   localparam logic [QUO_W-1:0] DIV_MIN5 = 32'd80;
   localparam logic [QUO_W-1:0] DIV_MIN3 = 32'd48;
   localparam logic [QUO_W-1:0] DIV_MIN2 = 32'd32;

   localparam logic [17:0] DUTY_FULL  = 18'd65535;
   localparam logic [17:0] DUTY_FULL2 = 18'd131070;
   localparam logic [17:0] LEVEL_MAX  = 18'd65535;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_TOO_HIGH = 2'd1;
   localparam logic [1:0] STATUS_TOO_LOW  = 2'd2;

   localparam logic REG_SYSTEM_CLOCK_HZ = 1'b0;

   typedef struct packed {
      logic [FREQ_W-1:0] tone_frequency;
      logic [DUTY_W-1:0] duty_value;
   } req_type;

   typedef struct packed {
      logic [DIV_W-1:0]   clock_divider;
      logic [WRAP_W-1:0]  wrap_count;
      logic [LEVEL_W-1:0] compare_level;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_FACTOR,
      ST_DECIDE,
      ST_FINISH,
      ST_MULTIPLY,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic fac_step;
      logic move;
      logic finish;
      logic multiply;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic freq_zero;
      logic div_last;
      logic fac_last;
      logic can_move;
   } sts_type;

endpackage

// ===== hdl/pwmdw_datapath.sv =====
// Datapath: serial divider, factor trials by five, three and two, range check and compare level.
module pwmdw_datapath #(
   parameter int unsigned WRAP_LIMIT = 65534
) (
   input  logic                      clock,
   input  pwmdw_pkg::req_type        req_data,
   input  logic [pwmdw_pkg::CLK_W-1:0] system_clock_hz,
   input  pwmdw_pkg::cmd_type        cmd,
   output pwmdw_pkg::sts_type        sts,
   output pwmdw_pkg::rsp_type        rsp_data
);
   import pwmdw_pkg::*;

   localparam logic [18:0] LIMIT_V = 19'(WRAP_LIMIT);

   logic [FREQ_W-1:0]  freq_ff;
   logic [DUTY_W-1:0]  duty_ff;
   logic               zero_ff;
   logic [QUO_W-1:0]   quo_ff;
   logic [FREQ_W-1:0]  rem_ff;
   logic [4:0]         bit_cnt_ff;
   logic [QUO_W-1:0]   sh_ff;
   logic [QUO_W-1:0]   q5_ff;
   logic [QUO_W-1:0]   q3_ff;
   logic [2:0]         r5_ff;
   logic [1:0]         r3_ff;
   logic [1:0]         dig_cnt_ff;
   logic [WRAP_W-1:0]  wrap_ff;
   logic [DIV_W-1:0]   res_div_ff;
   logic [WRAP_W-1:0]  res_wrap_ff;
   logic [1:0]         res_status_ff;
   logic [32:0]        prod_ff;
   rsp_type            rsp_ff;

   logic [FREQ_W:0]    div_t;
   logic               div_ge;
   logic [FREQ_W-1:0]  rem_in;
   logic [QUO_W-1:0]   quo_div_in;

   logic [QUO_W-1:0]   q5_in;
   logic [QUO_W-1:0]   q3_in;
   logic [2:0]         r5_in;
   logic [1:0]         r3_in;

   logic [18:0]        wrap5;
   logic [18:0]        wrap3;
   logic [18:0]        wrap2;
   logic               m5;
   logic               m3;
   logic               m2;
   logic [QUO_W-1:0]   quo_move_in;
   logic [WRAP_W-1:0]  wrap_move_in;

   logic [16:0]        wrap_p1;
   logic [16:0]        lvl_q;
   logic [17:0]        lvl_s;
   logic [17:0]        lvl_sum;
   logic [LEVEL_W-1:0] level;

   // One restoring quotient bit per step.
   always_comb begin
      div_t      = {rem_ff, quo_ff[QUO_W-1]};
      div_ge     = div_t >= {1'b0, freq_ff};
      rem_in     = div_ge ? 16'(div_t - {1'b0, freq_ff}) : div_t[FREQ_W-1:0];
      quo_div_in = {quo_ff[QUO_W-2:0], div_ge};
   end

   // Eight bits of long division by five and by three per step.
   always_comb begin
      logic [3:0] t5;
      logic [2:0] t3;
      r5_in = r5_ff;
      r3_in = r3_ff;
      q5_in = q5_ff;
      q3_in = q3_ff;
      for (int i = 0; i < 8; i++) begin
         t5 = {r5_in, sh_ff[QUO_W-1-i]};
         if (t5 >= 4'd5) begin
            r5_in = 3'(t5 - 4'd5);
            q5_in = {q5_in[QUO_W-2:0], 1'b1};
         end else begin
            r5_in = t5[2:0];
            q5_in = {q5_in[QUO_W-2:0], 1'b0};
         end
         t3 = {r3_in, sh_ff[QUO_W-1-i]};
         if (t3 >= 3'd3) begin
            r3_in = 2'(t3 - 3'd3);
            q3_in = {q3_in[QUO_W-2:0], 1'b1};
         end else begin
            r3_in = t3[1:0];
            q3_in = {q3_in[QUO_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      wrap5 = {3'd0, wrap_ff} * 19'd5;
      wrap3 = {3'd0, wrap_ff} * 19'd3;
      wrap2 = {2'd0, wrap_ff, 1'b0};
      m5 = (quo_ff >= DIV_MIN5) && (r5_ff == 3'd0) && (wrap5 <= LIMIT_V);
      m3 = (quo_ff >= DIV_MIN3) && (r3_ff == 2'd0) && (wrap3 <= LIMIT_V);
      m2 = (quo_ff >= DIV_MIN2) && (wrap2 <= LIMIT_V);
      if (m5) begin
         quo_move_in  = q5_ff;
         wrap_move_in = wrap5[WRAP_W-1:0];
      end else if (m3) begin
         quo_move_in  = q3_ff;
         wrap_move_in = wrap3[WRAP_W-1:0];
      end else begin
         quo_move_in  = {1'b0, quo_ff[QUO_W-1:1]};
         wrap_move_in = wrap2[WRAP_W-1:0];
      end
   end

   // The product divided by 65535 is its high half plus a correction of at most two.
   always_comb begin
      wrap_p1 = {1'b0, res_wrap_ff} + 17'd1;
      lvl_q   = prod_ff[32:16];
      lvl_s   = {1'b0, lvl_q} + {2'd0, prod_ff[15:0]};
      if (lvl_s >= DUTY_FULL2) begin
         lvl_sum = {1'b0, lvl_q} + 18'd2;
      end else if (lvl_s >= DUTY_FULL) begin
         lvl_sum = {1'b0, lvl_q} + 18'd1;
      end else begin
         lvl_sum = {1'b0, lvl_q};
      end
      level = (lvl_sum > LEVEL_MAX) ? LEVEL_MAX[LEVEL_W-1:0] : lvl_sum[LEVEL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         freq_ff    <= req_data.tone_frequency;
         duty_ff    <= req_data.duty_value;
         zero_ff    <= req_data.tone_frequency == '0;
         quo_ff     <= {system_clock_hz, 4'd0};
         rem_ff     <= '0;
         bit_cnt_ff <= '0;
         wrap_ff    <= 16'd1;
      end
      if (cmd.div_step) begin
         quo_ff     <= quo_div_in;
         rem_ff     <= rem_in;
         bit_cnt_ff <= bit_cnt_ff + 5'd1;
      end
      if (cmd.move) begin
         quo_ff  <= quo_move_in;
         wrap_ff <= wrap_move_in;
      end
      if (cmd.div_step || cmd.move) begin
         sh_ff      <= cmd.move ? quo_move_in : quo_div_in;
         r5_ff      <= '0;
         r3_ff      <= '0;
         dig_cnt_ff <= '0;
      end else if (cmd.fac_step) begin
         sh_ff      <= {sh_ff[QUO_W-9:0], 8'd0};
         q5_ff      <= q5_in;
         q3_ff      <= q3_in;
         r5_ff      <= r5_in;
         r3_ff      <= r3_in;
         dig_cnt_ff <= dig_cnt_ff + 2'd1;
      end
      if (cmd.finish) begin
         if (zero_ff) begin
            res_div_ff    <= '0;
            res_wrap_ff   <= '0;
            res_status_ff <= STATUS_TOO_LOW;
         end else if (quo_ff < DIV_MIN) begin
            res_div_ff    <= '0;
            res_wrap_ff   <= '0;
            res_status_ff <= STATUS_TOO_HIGH;
         end else if (quo_ff >= DIV_MAX) begin
            res_div_ff    <= '0;
            res_wrap_ff   <= '0;
            res_status_ff <= STATUS_TOO_LOW;
         end else begin
            res_div_ff    <= quo_ff[DIV_W-1:0];
            res_wrap_ff   <= wrap_ff;
            res_status_ff <= STATUS_OK;
         end
      end
      if (cmd.multiply) begin
         prod_ff <= {17'd0, duty_ff} * {16'd0, wrap_p1};
      end
      if (cmd.publish) begin
         rsp_ff.clock_divider <= res_div_ff;
         rsp_ff.wrap_count    <= res_wrap_ff;
         rsp_ff.compare_level <= level;
         rsp_ff.status        <= res_status_ff;
      end
   end

   assign sts.freq_zero = zero_ff;
   assign sts.div_last  = bit_cnt_ff == 5'd31;
   assign sts.fac_last  = dig_cnt_ff == 2'd3;
   assign sts.can_move  = m5 || m3 || m2;
   assign rsp_data      = rsp_ff;

endmodule

// ===== hdl/pwmdw_controller.sv =====
// Controller: sequences the divide, the factor trials and the result transfer.
module pwmdw_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  pwmdw_pkg::sts_type sts,
   output pwmdw_pkg::cmd_type cmd
);
   import pwmdw_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (sts.freq_zero) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_step = 1'b1;
               if (sts.div_last) begin
                  state_in = ST_FACTOR;
               end
            end
         end
         ST_FACTOR: begin
            cmd.fac_step = 1'b1;
            if (sts.fac_last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (sts.can_move) begin
               cmd.move = 1'b1;
               state_in = ST_FACTOR;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_MULTIPLY;
         end
         ST_MULTIPLY: begin
            cmd.multiply = 1'b1;
            state_in     = ST_PUBLISH;
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/pwm_divider_wrap_solver_top.sv =====
// Top level of the PWM divider and wrap solver with its register port.
//
// For each tone frequency and duty value transferred in, the block returns one result: the
// clock divider in 8.4 form, the wrap count, the compare level and a status. The divider
// 16*system_clock_hz/tone_frequency is formed one quotient bit a cycle; then each factor
// trial runs byte-serial division by five and three over four bytes and then decides, with
// at most 16 trials; the range check, the compare multiply and the result register follow,
// and then the idle state. A zero frequency skips the divide and the factor trials. A new
// item is taken only after the previous one has reached the result register, where it waits
// to be taken. The system clock register sits at byte address 0; the user must write it only
// while the block is idle, and the block itself does not enforce this.
module pwm_divider_wrap_solver_top #(
   parameter int unsigned WRAP_LIMIT = 65534
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  pwmdw_pkg::req_type           req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output pwmdw_pkg::rsp_type           rsp_data,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [pwmdw_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import pwmdw_pkg::*;

   logic [CLK_W-1:0] system_clock_hz_ff;
   logic             csr_hit;
   cmd_type          cmd;
   sts_type          sts;

   assign csr_hit    = csr_paddr[ADDR_W-1] == REG_SYSTEM_CLOCK_HZ;
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {4'd0, system_clock_hz_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         system_clock_hz_ff <= CLK_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         system_clock_hz_ff <= csr_pwdata[CLK_W-1:0];
      end
   end

   pwmdw_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pwmdw_datapath #(
      .WRAP_LIMIT (WRAP_LIMIT)
   ) u_datapath (
      .clock           (clock),
      .req_data        (req_data),
      .system_clock_hz (system_clock_hz_ff),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_data        (rsp_data)
   );

endmodule
